// ===== design/ddo_pkg.sv =====
// Shared constants, types and the arctangent table of the odometry block.
`default_nettype none
package ddo_pkg;

	// Channel and register widths.
	localparam int COUNT_W = 32;
	localparam int POS_W = 32;
	localparam int HEAD_W = 31;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int MPT_W = 32;
	localparam int IWB_W = 24;

	// Datapath widths.
	localparam int ANG_W = 32;
	localparam int CRD_W = 34;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 33;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int ATAN_IDX_W = 5;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [HEAD_W-1:0] head_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	localparam cfg_idx_t REG_METRES_PER_TICK = 4'd0;
	localparam cfg_idx_t REG_INV_WHEEL_BASE = 4'd1;

	localparam logic [MPT_W-1:0] MPT_RESET = 32'd1519990;
	localparam logic [IWB_W-1:0] IWB_RESET = 24'd504123;

	// Angles in Q3.28, CORDIC values in Q3.30.
	localparam ang_t PI_Q28 = 32'sd843314857;
	localparam ang_t TWO_PI_Q28 = 32'sd1686629713;
	localparam ang_t HALF_PI_Q28 = 32'sd421657428;
	localparam crd_t CORDIC_K = 34'sd652032874;
	localparam crd_t ONE_Q30 = 34'sd1073741824;

	function automatic ang_t atan_q28(input logic [ATAN_IDX_W-1:0] idx);
		ang_t r;
		case (idx)
			5'd0: r = 32'sd210828714;
			5'd1: r = 32'sd124459457;
			5'd2: r = 32'sd65760959;
			5'd3: r = 32'sd33381290;
			5'd4: r = 32'sd16755422;
			5'd5: r = 32'sd8385879;
			5'd6: r = 32'sd4193963;
			5'd7: r = 32'sd2097109;
			5'd8: r = 32'sd1048571;
			5'd9: r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/ddo_ifs.sv =====
// Valid/ready channel interfaces for encoder input, pose output and register writes.
`default_nettype none
interface ddo_in_if import ddo_pkg::*; ();
	logic valid;
	logic ready;
	count_t left_count;
	count_t right_count;

	modport source(output valid, left_count, right_count, input ready);
	modport sink(input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
	logic valid;
	logic ready;
	pos_t x_pos;
	pos_t y_pos;
	head_t heading;

	modport source(output valid, x_pos, y_pos, heading, input ready);
	modport sink(input valid, x_pos, y_pos, heading, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_t index;
	cfg_data_t data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/diff_drive_odometry_unit.sv =====
// Top level of the differential-drive odometry block: sequencer, pose state and channels.
//
//   channel  | modport | payload                        | transfer when
//   in_ch    | sink    | left_count, right_count        | valid && ready
//   out_ch   | source  | x_pos, y_pos, heading          | valid && ready
//   cfg      | sink    | index, data (ready always high)| valid && ready
//
// The first encoder pair after reset only primes the stored counts and returns to idle.
// Every later pair runs the whole state sequence from transfer to result, its length
// set by the CORDIC iterations and the five passes through the one shared multiplier.
// A new pair is taken only while the sequencer is idle; the result register may still
// hold an earlier result then. If that result is not yet taken, the sequencer waits in S_OUT.
// arst_n clears the sequencer, the pose, the stored counts and the registers to defaults.
`default_nettype none
module diff_drive_odometry_unit import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	ddo_in_if.sink in_ch,
	ddo_out_if.source out_ch,
	ddo_cfg_if.sink cfg
);
	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MUL_L  = 13'b0000000000010,
		S_MUL_R  = 13'b0000000000100,
		S_DR     = 13'b0000000001000,
		S_SUM    = 13'b0000000010000,
		S_MUL_TH = 13'b0000000100000,
		S_TH     = 13'b0000001000000,
		S_MID    = 13'b0000010000000,
		S_CORD   = 13'b0000100000000,
		S_MUL_X  = 13'b0001000000000,
		S_MUL_Y  = 13'b0010000000000,
		S_Y      = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	localparam int DW = 49;
	localparam int SW = 50;
	localparam int VW = 40;

	localparam logic signed [PROD_W-1:0] HALF16 = 68'sd32768;
	localparam logic signed [PROD_W-1:0] HALF4 = 68'sd8;
	localparam logic signed [PROD_W-1:0] HALF30 = 68'sd536870912;
	localparam logic signed [PROD_W-1:0] PI_P = 68'sd843314857;
	localparam logic signed [SW-1:0] TRAV_HI = 50'sd4294967296;
	localparam logic signed [SW-1:0] DIFF_HI = 50'sd17179869183;
	localparam logic signed [VW-1:0] POS_HI = 40'sd2147483647;
	localparam logic signed [VW-1:0] POS_LO = -40'sd2147483648;

	state_t state_q;
	logic first_q;
	count_t last_l_q;
	count_t last_r_q;
	logic [MPT_W-1:0] mpt_q;
	logic [IWB_W-1:0] iwb_q;

	logic signed [COUNT_W-1:0] dl_q;
	logic signed [COUNT_W-1:0] dr_q;
	logic signed [DW-1:0] dL_q;
	logic signed [DW-1:0] dR_q;
	logic signed [33:0] travel_q;
	logic signed [MUL_A_W-1:0] diff_q;
	head_t dth_q;
	head_t angle_q;
	logic flip_q;
	logic signed [31:0] c_q;
	logic signed [31:0] s_q;
	pos_t pos_x_q;
	pos_t pos_y_q;

	logic out_valid_q;
	pos_t out_x_q;
	pos_t out_y_q;
	head_t out_h_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] r16;
	logic signed [PROD_W-1:0] r4;
	logic signed [PROD_W-1:0] r30;
	logic signed [SW-1:0] sum_w;
	logic signed [SW-1:0] half_w;
	logic signed [SW-1:0] dif_w;
	ang_t ang_x;
	ang_t mid0;
	ang_t mid_z;
	logic mid_flip;
	ang_t ang_new;
	ang_t ang_wrap;
	logic crd_start;
	logic crd_done;
	crd_t crd_x;
	crd_t crd_y;
	logic signed [31:0] c_cl;
	logic signed [31:0] s_cl;
	logic signed [VW-1:0] pos_base;
	logic signed [VW-1:0] pos_sum;
	pos_t pos_sat;
	logic in_xfer;
	logic out_free;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer = in_ch.valid && (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || out_ch.ready;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			S_MUL_L: begin
				mul_a = {{3{dl_q[31]}}, dl_q};
				mul_b = {1'b0, mpt_q};
			end
			S_MUL_R: begin
				mul_a = {{3{dr_q[31]}}, dr_q};
				mul_b = {1'b0, mpt_q};
			end
			S_MUL_TH: begin
				mul_a = diff_q;
				mul_b = {9'd0, iwb_q};
			end
			S_MUL_X: begin
				mul_a = {travel_q[33], travel_q};
				mul_b = {c_q[31], c_q};
			end
			S_MUL_Y: begin
				mul_a = {travel_q[33], travel_q};
				mul_b = {s_q[31], s_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ddo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	assign crd_start = (state_q == S_MID);

	ddo_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (crd_start),
		.z_in  (mid_z),
		.done  (crd_done),
		.x_out (crd_x),
		.y_out (crd_y)
	);

	// Rounded views of the product for each use.
	assign r16 = (prod + HALF16) >>> 16;
	assign r4 = (prod + HALF4) >>> 4;
	assign r30 = (prod + HALF30) >>> 30;

	// Centre travel and wheel difference.
	assign sum_w = {dL_q[DW-1], dL_q} + {dR_q[DW-1], dR_q};
	assign half_w = sum_w >>> 1;
	assign dif_w = {dR_q[DW-1], dR_q} - {dL_q[DW-1], dL_q};

	// Midpoint heading, folded into plus or minus half pi for the CORDIC.
	assign ang_x = {angle_q[HEAD_W-1], angle_q};
	assign mid0 = ang_x + {{2{dth_q[HEAD_W-1]}}, dth_q[HEAD_W-1:1]};
	always_comb begin
		if (mid0 > HALF_PI_Q28) begin
			mid_z = mid0 - PI_Q28;
			mid_flip = 1'b1;
		end else if (mid0 < -HALF_PI_Q28) begin
			mid_z = mid0 + PI_Q28;
			mid_flip = 1'b1;
		end else begin
			mid_z = mid0;
			mid_flip = 1'b0;
		end
	end

	assign ang_new = ang_x + {dth_q[HEAD_W-1], dth_q};
	always_comb begin
		if (ang_new > PI_Q28) begin
			ang_wrap = ang_new - TWO_PI_Q28;
		end else if (ang_new < -PI_Q28) begin
			ang_wrap = ang_new + TWO_PI_Q28;
		end else begin
			ang_wrap = ang_new;
		end
	end

	// Clamp each component of the rotated vector to the range minus one to one.
	always_comb begin
		if (crd_x > ONE_Q30) begin
			c_cl = 32'sd1073741824;
		end else if (crd_x < -ONE_Q30) begin
			c_cl = -32'sd1073741824;
		end else begin
			c_cl = crd_x[31:0];
		end
		if (crd_y > ONE_Q30) begin
			s_cl = 32'sd1073741824;
		end else if (crd_y < -ONE_Q30) begin
			s_cl = -32'sd1073741824;
		end else begin
			s_cl = crd_y[31:0];
		end
	end

	// One saturating adder serves both position axes.
	assign pos_base = (state_q == S_MUL_Y) ? {{8{pos_x_q[31]}}, pos_x_q}
		: {{8{pos_y_q[31]}}, pos_y_q};
	assign pos_sum = pos_base + r30[VW-1:0];
	always_comb begin
		if (pos_sum > POS_HI) begin
			pos_sat = 32'sh7fffffff;
		end else if (pos_sum < POS_LO) begin
			pos_sat = 32'sh80000000;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b1;
			last_l_q <= '0;
			last_r_q <= '0;
			mpt_q <= MPT_RESET;
			iwb_q <= IWB_RESET;
			angle_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_METRES_PER_TICK) begin
					mpt_q <= cfg.data[MPT_W-1:0];
				end else if (cfg.index == REG_INV_WHEEL_BASE) begin
					iwb_q <= cfg.data[IWB_W-1:0];
				end
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_l_q <= in_ch.left_count;
						last_r_q <= in_ch.right_count;
						if (first_q) begin
							first_q <= 1'b0;
						end else begin
							state_q <= S_MUL_L;
						end
					end
				end
				S_MUL_L: state_q <= S_MUL_R;
				S_MUL_R: state_q <= S_DR;
				S_DR: state_q <= S_SUM;
				S_SUM: state_q <= S_MUL_TH;
				S_MUL_TH: state_q <= S_TH;
				S_TH: state_q <= S_MID;
				S_MID: begin
					angle_q <= ang_wrap[HEAD_W-1:0];
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (crd_done) begin
						state_q <= S_MUL_X;
					end
				end
				S_MUL_X: state_q <= S_MUL_Y;
				S_MUL_Y: begin
					pos_x_q <= pos_sat;
					state_q <= S_Y;
				end
				S_Y: begin
					pos_y_q <= pos_sat;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dl_q <= in_ch.left_count - last_l_q;
			dr_q <= in_ch.right_count - last_r_q;
		end
		if (state_q == S_MUL_R) begin
			dL_q <= r16[DW-1:0];
		end
		if (state_q == S_DR) begin
			dR_q <= r16[DW-1:0];
		end
		if (state_q == S_SUM) begin
			if (half_w > TRAV_HI) begin
				travel_q <= 34'sd4294967296;
			end else if (half_w < -TRAV_HI) begin
				travel_q <= -34'sd4294967296;
			end else begin
				travel_q <= half_w[33:0];
			end
			if (dif_w > DIFF_HI) begin
				diff_q <= DIFF_HI[MUL_A_W-1:0];
			end else if (dif_w < -DIFF_HI) begin
				diff_q <= -(DIFF_HI[MUL_A_W-1:0]);
			end else begin
				diff_q <= dif_w[MUL_A_W-1:0];
			end
		end
		if (state_q == S_TH) begin
			if (r4 > PI_P) begin
				dth_q <= PI_Q28[HEAD_W-1:0];
			end else if (r4 < -PI_P) begin
				dth_q <= -(PI_Q28[HEAD_W-1:0]);
			end else begin
				dth_q <= r4[HEAD_W-1:0];
			end
		end
		if (state_q == S_MID) begin
			flip_q <= mid_flip;
		end
		if (state_q == S_CORD && crd_done) begin
			c_q <= flip_q ? -c_cl : c_cl;
			s_q <= flip_q ? -s_cl : s_cl;
		end
		if (state_q == S_OUT && out_free) begin
			out_x_q <= pos_x_q;
			out_y_q <= pos_y_q;
			out_h_q <= angle_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.x_pos = out_x_q;
	assign out_ch.y_pos = out_y_q;
	assign out_ch.heading = out_h_q;
endmodule
`default_nettype wire

// ===== design/ddo_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module ddo_mul import ddo_pkg::*; (
	input logic clk,
	input logic signed [MUL_A_W-1:0] a,
	input logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0] prod
);
	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ===== design/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`default_nettype none
module ddo_cordic import ddo_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ang_t z_in,
	output logic done,
	output crd_t x_out,
	output crd_t y_out
);
	localparam int CW = $clog2(STEPS);
	localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

	logic run_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	crd_t x_q;
	crd_t y_q;
	ang_t z_q;
	crd_t xs;
	crd_t ys;
	ang_t at;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = atan_q28(ATAN_IDX_W'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_K;
			y_q <= '0;
			z_q <= z_in;
		end else if (run_q) begin
			if (!z_q[ANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
endmodule
`default_nettype wire
